// ----- sv/qmlp_pkg.sv -----
// Shared constants, types and helper functions of the quantized MLP block.
// No dependencies; imported by every module of the block.
package qmlp_pkg;
   localparam int INPUT_COUNT  = 2;
   localparam int FIRST_WIDTH  = 16;
   localparam int SECOND_WIDTH = 8;
   localparam int THIRD_WIDTH  = 4;
   localparam int SCALE_SHIFT  = 17;

   localparam int WEIGHT_AW = 8;
   localparam int BIAS_AW   = 5;
   localparam int ACT_AW    = 4;
   localparam int CNT_W     = ACT_AW + 1;
   localparam int PROD_W    = 49;

   localparam logic [1:0] OP_WRITE_WEIGHT = 2'd0;
   localparam logic [1:0] OP_WRITE_BIAS   = 2'd1;
   localparam logic [1:0] OP_INFER        = 2'd2;

   localparam logic [2:0] CSR_NET_IN_ZP = 3'd0;
   localparam logic [2:0] CSR_HIDDEN_ZP = 3'd1;
   localparam logic [2:0] CSR_SCALE_L1  = 3'd2;
   localparam logic [2:0] CSR_SCALE_L2  = 3'd3;
   localparam logic [2:0] CSR_SCALE_L3  = 3'd4;
   localparam logic [2:0] CSR_SCALE_L4  = 3'd5;

   localparam logic [1:0] LAST_LAYER = 2'd3;

   typedef struct packed {
      logic load_bias;
      logic mac;
      logic mul;
   } dp_ctrl_type;

   function automatic logic [CNT_W-1:0] fan_in(input logic [1:0] layer);
      case (layer)
         2'd0:    fan_in = CNT_W'(INPUT_COUNT);
         2'd1:    fan_in = CNT_W'(FIRST_WIDTH);
         2'd2:    fan_in = CNT_W'(SECOND_WIDTH);
         default: fan_in = CNT_W'(THIRD_WIDTH);
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] fan_out(input logic [1:0] layer);
      case (layer)
         2'd0:    fan_out = CNT_W'(FIRST_WIDTH);
         2'd1:    fan_out = CNT_W'(SECOND_WIDTH);
         2'd2:    fan_out = CNT_W'(THIRD_WIDTH);
         default: fan_out = CNT_W'(1);
      endcase
   endfunction
endpackage

// ----- sv/qmlp_req_if.sv -----
// Request channel: valid/ready handshake carrying one command item.
// No dependencies; plain fixed widths.
interface qmlp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [7:0]         entry_address;
   logic signed [7:0]  weight_value;
   logic signed [31:0] bias_value;
   logic signed [7:0]  sample_first;
   logic signed [7:0]  sample_second;

   modport source (output valid, opcode, entry_address, weight_value, bias_value,
                   sample_first, sample_second, input ready);
   modport sink (input valid, opcode, entry_address, weight_value, bias_value,
                 sample_first, sample_second, output ready);
endinterface

// ----- sv/qmlp_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one prediction item.
// No dependencies.
interface qmlp_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] prediction;

   modport source (output valid, prediction, input ready);
   modport sink (input valid, prediction, output ready);
endinterface

// ----- sv/quantized_mlp_inference.sv -----
// Quantized int8 MLP (2-16-8-4-1): top level with sequencer and registers.
// Depends on qmlp_pkg, qmlp_req_if, qmlp_rsp_if, qmlp_param_store,
// qmlp_act_ram and qmlp_datapath.
//
// Write items (weight, bias, unused opcode) are accepted whenever idle. An
// infer item runs every neuron through one shared MAC fed by the weight
// memory: each neuron steps through bias read, one MAC per weight, drain,
// scale multiply, requantize and write-back. No item is taken during an
// inference; the prediction waits in an output register until taken.
module quantized_mlp_inference (
   input  logic         clock,
   input  logic         reset,
   qmlp_req_if.sink     req_bus,
   qmlp_rsp_if.source   rsp_bus,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import qmlp_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BIAS  = 6'b000010,
      ST_MAC   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic signed [7:0] net_zp_ff, hid_zp_ff;
   logic [15:0]       scale_ff [4];

   logic [1:0]           layer_ff, layer_in;
   logic [CNT_W-1:0]     neuron_ff, neuron_in, tap_ff, tap_in;
   logic [ACT_AW-1:0]    tap_d_ff;
   logic [WEIGHT_AW-1:0] waddr_ff, waddr_in;
   logic [BIAS_AW-1:0]   baddr_ff, baddr_in;
   logic                 bank_ff, bank_in;
   logic                 ld_bias_ff, mac_ff;
   logic signed [7:0]    s0_ff, s1_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]    rsp_data_ff;

   logic        req_fire, rsp_free, out_load;
   logic        w_we, b_we;
   logic [7:0]  w_rdata, act_rdata;
   logic [31:0] b_rdata;
   logic signed [7:0] act_val, result;
   dp_ctrl_type ctrl;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign w_we = req_fire && (req_bus.opcode == OP_WRITE_WEIGHT);
   assign b_we = req_fire && (req_bus.opcode == OP_WRITE_BIAS)
                 && (req_bus.entry_address[7:BIAS_AW] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         net_zp_ff   <= 8'sd0;
         hid_zp_ff   <= -8'sd128;
         scale_ff[0] <= 16'd952;
         scale_ff[1] <= 16'd1592;
         scale_ff[2] <= 16'd1212;
         scale_ff[3] <= 16'd2995;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NET_IN_ZP: net_zp_ff   <= csr_data[7:0];
            CSR_HIDDEN_ZP: hid_zp_ff   <= csr_data[7:0];
            CSR_SCALE_L1:  scale_ff[0] <= csr_data;
            CSR_SCALE_L2:  scale_ff[1] <= csr_data;
            CSR_SCALE_L3:  scale_ff[2] <= csr_data;
            CSR_SCALE_L4:  scale_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      layer_in     = layer_ff;
      neuron_in    = neuron_ff;
      tap_in       = tap_ff;
      waddr_in     = waddr_ff;
      baddr_in     = baddr_ff;
      bank_in      = bank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.opcode == OP_INFER) begin
               state_in  = ST_BIAS;
               layer_in  = '0;
               neuron_in = '0;
               waddr_in  = '0;
               baddr_in  = '0;
               bank_in   = 1'b0;
            end
         end
         ST_BIAS: begin
            tap_in   = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            waddr_in = waddr_ff + 1'b1;
            tap_in   = tap_ff + 1'b1;
            if (tap_ff == fan_in(layer_ff) - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_WRITE;
         ST_WRITE: begin
            if (layer_ff != LAST_LAYER || rsp_free) begin
               baddr_in  = baddr_ff + 1'b1;
               neuron_in = neuron_ff + 1'b1;
               state_in  = ST_BIAS;
               if (neuron_ff == fan_out(layer_ff) - 1'b1) begin
                  neuron_in = '0;
                  layer_in  = layer_ff + 1'b1;
                  bank_in   = !bank_ff;
                  if (layer_ff == LAST_LAYER) begin
                     state_in     = ST_IDLE;
                     out_load     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         layer_ff     <= '0;
         neuron_ff    <= '0;
         tap_ff       <= '0;
         waddr_ff     <= '0;
         baddr_ff     <= '0;
         bank_ff      <= 1'b0;
         ld_bias_ff   <= 1'b0;
         mac_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         layer_ff     <= layer_in;
         neuron_ff    <= neuron_in;
         tap_ff       <= tap_in;
         waddr_ff     <= waddr_in;
         baddr_ff     <= baddr_in;
         bank_ff      <= bank_in;
         ld_bias_ff   <= (state_ff == ST_BIAS);
         mac_ff       <= (state_ff == ST_MAC);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_d_ff <= tap_ff[ACT_AW-1:0];
      if (req_fire && req_bus.opcode == OP_INFER) begin
         s0_ff <= req_bus.sample_first;
         s1_ff <= req_bus.sample_second;
      end
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   // layer one takes the samples directly; further inputs read as zero
   always_comb begin
      if (layer_ff != 2'd0) begin
         act_val = act_rdata;
      end else if (tap_d_ff == '0) begin
         act_val = s0_ff;
      end else if (tap_d_ff == ACT_AW'(1) && INPUT_COUNT > 1) begin
         act_val = s1_ff;
      end else begin
         act_val = 8'sd0;
      end
   end

   assign ctrl.load_bias = ld_bias_ff;
   assign ctrl.mac       = mac_ff;
   assign ctrl.mul       = (state_ff == ST_SCALE);

   qmlp_param_store u_store (
      .clock   (clock),
      .w_we    (w_we),
      .w_waddr (req_bus.entry_address),
      .w_wdata (req_bus.weight_value),
      .w_raddr (waddr_ff),
      .w_rdata (w_rdata),
      .b_we    (b_we),
      .b_waddr (req_bus.entry_address[BIAS_AW-1:0]),
      .b_wdata (req_bus.bias_value),
      .b_raddr (baddr_ff),
      .b_rdata (b_rdata)
   );

   qmlp_act_ram u_act (
      .clock (clock),
      .we    (state_ff == ST_WRITE && (layer_ff != LAST_LAYER || rsp_free)),
      .waddr ({!bank_ff, neuron_ff[ACT_AW-1:0]}),
      .wdata (result),
      .raddr ({bank_ff, tap_ff[ACT_AW-1:0]}),
      .rdata (act_rdata)
   );

   qmlp_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .bias   (b_rdata),
      .weight (w_rdata),
      .act    (act_val),
      .in_zp  ((layer_ff == 2'd0) ? net_zp_ff : hid_zp_ff),
      .out_zp (hid_zp_ff),
      .scale  (scale_ff[layer_ff]),
      .result (result)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.prediction = rsp_data_ff;
endmodule

// ----- sv/qmlp_param_store.sv -----
// Weight and bias memories, one write and one registered read port each.
// Depends on qmlp_pkg.
module qmlp_param_store (
   input  logic                         clock,
   input  logic                         w_we,
   input  logic [qmlp_pkg::WEIGHT_AW-1:0] w_waddr,
   input  logic [7:0]                   w_wdata,
   input  logic [qmlp_pkg::WEIGHT_AW-1:0] w_raddr,
   output logic [7:0]                   w_rdata,
   input  logic                         b_we,
   input  logic [qmlp_pkg::BIAS_AW-1:0] b_waddr,
   input  logic [31:0]                  b_wdata,
   input  logic [qmlp_pkg::BIAS_AW-1:0] b_raddr,
   output logic [31:0]                  b_rdata
);
   import qmlp_pkg::*;

   logic [7:0]  weight_mem [2**WEIGHT_AW];
   logic [31:0] bias_mem [2**BIAS_AW];

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= w_wdata;
      end
      w_rdata <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_mem[b_waddr] <= b_wdata;
      end
      b_rdata <= bias_mem[b_raddr];
   end
endmodule

// ----- sv/qmlp_act_ram.sv -----
// Activation memory, two banks of 16 entries used ping-pong across layers.
// Depends on qmlp_pkg.
module qmlp_act_ram (
   input  logic                      clock,
   input  logic                      we,
   input  logic [qmlp_pkg::ACT_AW:0] waddr,
   input  logic [7:0]                wdata,
   input  logic [qmlp_pkg::ACT_AW:0] raddr,
   output logic [7:0]                rdata
);
   import qmlp_pkg::*;

   logic [7:0] act_mem [2**(ACT_AW+1)];

   always_ff @(posedge clock) begin
      if (we) begin
         act_mem[waddr] <= wdata;
      end
      rdata <= act_mem[raddr];
   end
endmodule

// ----- sv/qmlp_datapath.sv -----
// Accumulator, shared 8x9 MAC and the requantize stage (wide scale product,
// arithmetic shift, zero point add, clamp). Depends on qmlp_pkg.
module qmlp_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  qmlp_pkg::dp_ctrl_type    ctrl,
   input  logic signed [31:0]       bias,
   input  logic signed [7:0]        weight,
   input  logic signed [7:0]        act,
   input  logic signed [7:0]        in_zp,
   input  logic signed [7:0]        out_zp,
   input  logic [15:0]              scale,
   output logic signed [7:0]        result
);
   import qmlp_pkg::*;

   logic signed [31:0]       acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [8:0]        diff;
   logic signed [16:0]       term;
   logic signed [PROD_W-1:0] shifted, biased;

   always_comb begin
      diff = 9'(act) - 9'(in_zp);
      term = 17'(weight) * 17'(diff);
      acc_in = acc_ff;
      if (ctrl.load_bias) begin
         acc_in = bias;
      end else if (ctrl.mac) begin
         acc_in = acc_ff + 32'(term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= PROD_W'(acc_ff) * $signed({{(PROD_W-16){1'b0}}, scale});
      end
   end

   // floor shift, then clamp to the symmetric int8 range
   always_comb begin
      shifted = prod_ff >>> SCALE_SHIFT;
      biased  = shifted + PROD_W'(out_zp);
      if (biased > PROD_W'(127)) begin
         result = 8'sd127;
      end else if (biased < -PROD_W'(127)) begin
         result = -8'sd127;
      end else begin
         result = biased[7:0];
      end
   end
endmodule
